FILE: rtl/core/srf_pkg.sv
// shared types and constants for the sequence replay filter
`timescale 1ns / 1ps

package srf_pkg;

  localparam int SEQ_W         = 64;
  localparam int DEPTH_DEFAULT = 32;

  // probe token walking down the cell row
  typedef struct packed {
    logic active;
    logic hit;
  } srf_probe_t;

  // one stored history entry
  typedef struct packed {
    logic             valid;
    logic [SEQ_W-1:0] data;
  } srf_entry_t;

endpackage

FILE: rtl/core/srf_cell.sv
// one history cell: holds an entry, checks the passing probe, shifts on record
`timescale 1ns / 1ps

module srf_cell import srf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [SEQ_W-1:0] probe_seq,
  input  logic             shift_en,
  input  srf_probe_t       probe_in,
  output srf_probe_t       probe_out,
  input  srf_entry_t       entry_in,
  output srf_entry_t       entry_out
);

  srf_probe_t probe;
  srf_entry_t entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe       <= '0;
      entry.valid <= 1'b0;
    end else begin
      probe.active <= probe_in.active;
      probe.hit    <= probe_in.hit |
                      (probe_in.active && entry.valid && (entry.data == probe_seq));
      if (shift_en) begin
        entry <= entry_in;
      end
    end
  end

  assign probe_out = probe;
  assign entry_out = entry;

endmodule

FILE: rtl/core/sequence_replay_filter_unit.sv
// anti-replay sequence window: top level with a row of history cells
// the item is registered, the probe then walks the DEPTH cells, and done is registered behind the tail
// no new item is taken while busy, that is until the probe has left the tail cell and done is shown
// a new item may be accepted in the same cycle that done is shown
// reset (rst, synchronous) empties the history and clears the highest sequence
// results cannot be stalled: done is a one-cycle strobe with replayed and highest_seq
`timescale 1ns / 1ps

module sequence_replay_filter_unit import srf_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             action,
  input  logic [SEQ_W-1:0] seq,
  output logic             done,
  output logic             replayed,
  output logic [SEQ_W-1:0] highest_seq
);

  // item registers, held while the probe walks the row
  logic             launch;
  logic [SEQ_W-1:0] seq_q;
  logic             action_q;
  logic             too_old_q;
  logic [SEQ_W-1:0] highest;

  logic             accept;
  logic             verdict;
  logic             shift_en;

  // probe links: link i feeds cell i, link DEPTH comes off the tail
  srf_probe_t       probe_link [DEPTH+1];
  // entry links: link i feeds cell i; the head takes the new sequence
  srf_entry_t       entry_link [DEPTH];

  assign accept = start && !busy;

  // the probe starts clean in the cycle after the item is taken
  assign probe_link[0] = '{active: launch, hit: 1'b0};
  assign entry_link[0] = '{valid: 1'b1, data: seq_q};

  // verdict is ready once the probe leaves the last cell
  assign verdict  = too_old_q | probe_link[DEPTH].hit;
  // a fresh record pushes every entry one cell down; the oldest falls off the tail
  assign shift_en = probe_link[DEPTH].active && action_q && !verdict;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      srf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .probe_seq (seq_q),
        .shift_en  (shift_en),
        .probe_in  (probe_link[i]),
        .probe_out (probe_link[i+1]),
        .entry_in  (entry_link[i]),
        .entry_out ()
      );
    end else begin : g_body
      srf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .probe_seq (seq_q),
        .shift_en  (shift_en),
        .probe_in  (probe_link[i]),
        .probe_out (probe_link[i+1]),
        .entry_in  (entry_link[i]),
        .entry_out (entry_link[i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      launch  <= 1'b0;
      done    <= 1'b0;
      highest <= '0;
    end else begin
      launch <= accept;
      done   <= 1'b0;
      if (accept) begin
        busy     <= 1'b1;
        seq_q    <= seq;
        action_q <= action;
        // too old: strictly below highest by at least the window size
        too_old_q <= (seq < highest) && ((highest - seq) >= SEQ_W'(DEPTH));
      end
      if (probe_link[DEPTH].active) begin
        busy     <= 1'b0;
        done     <= 1'b1;
        replayed <= verdict;
        if (shift_en && (seq_q > highest)) begin
          highest <= seq_q;
        end
      end
    end
  end

  assign highest_seq = highest;

endmodule

FILE: rtl/core/srf_checker.sv
// port-level checks for the sequence replay filter, bound to the top level
`timescale 1ns / 1ps

module srf_checker import srf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic             replayed,
  input logic [SEQ_W-1:0] highest_seq
);

  // a taken item keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after item accepted");

  // the result strobe marks the end of the item
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high with result strobe");

  // results are never back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // highest only moves together with a result
  a_highest_hold: assert property (@(posedge clk) disable iff (rst)
    (!done && !$past(rst)) |-> $stable(highest_seq))
    else $error("highest changed without a result");

  // a rejected item leaves highest untouched
  a_replay_hold: assert property (@(posedge clk) disable iff (rst)
    (done && replayed && !$past(rst)) |-> $stable(highest_seq))
    else $error("highest changed on a replayed item");

endmodule

bind sequence_replay_filter_unit srf_checker u_srf_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .replayed    (replayed),
  .highest_seq (highest_seq)
);

FILE: verif/tb_top.sv
// self-checking testbench for the sequence replay filter unit
`timescale 1ns / 1ps

module tb_top;
  import srf_pkg::*;

  localparam int WIN         = DEPTH_DEFAULT;
  // slowest run is roughly 600 items x (one full busy period + worst sender gap)
  // so this leaves a wide margin
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_GAP     = 2 * WIN + 4;

  // one expected verdict, in the order items were accepted
  typedef struct {
    logic             replayed;
    logic [SEQ_W-1:0] highest;
  } verdict_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             action = 1'b0;
  logic [SEQ_W-1:0] seq = '0;
  logic             busy;
  logic             done;
  logic             replayed;
  logic [SEQ_W-1:0] highest_seq;

  // predicted window state
  logic [SEQ_W-1:0] win_top = '0;
  logic [SEQ_W-1:0] ring [WIN];
  int unsigned      ring_wr = 0;
  int unsigned      ring_fill = 0;

  // recently recorded sequences, reused to build replays (including evicted ones)
  logic [SEQ_W-1:0] recent_q[$];
  verdict_t         verdict_q[$];

  int               err_cnt = 0;
  int               idle_pct = 0;
  int unsigned      cycles = 0;

  sequence_replay_filter_unit #(.DEPTH(WIN)) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .seq        (seq),
    .done       (done),
    .replayed   (replayed),
    .highest_seq(highest_seq)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // too old (WIN or more below the top) or still present in the valid part of the ring
  function automatic logic seen_before(input logic [SEQ_W-1:0] s);
    if (s < win_top && (win_top - s) >= WIN)
      return 1'b1;
    // only filled slots are compared, so unwritten entries are never read
    for (int i = 0; i < ring_fill; i++)
      if (ring[i] == s)
        return 1'b1;
    return 1'b0;
  endfunction

  // advance the predicted window for one accepted item and queue its verdict
  function automatic void admit_packet(input logic act, input logic [SEQ_W-1:0] s);
    verdict_t v;
    logic     rep;
    rep = seen_before(s);
    if (act && !rep) begin
      ring[ring_wr] = s;
      ring_wr = (ring_wr + 1) % WIN;
      if (ring_fill < WIN)
        ring_fill++;
      if (s > win_top)
        win_top = s;
      recent_q.push_back(s);
      if (recent_q.size() > 2 * WIN)
        void'(recent_q.pop_front());
    end
    // a query or a rejected record leaves the top unchanged
    v.replayed = rep;
    v.highest  = win_top;
    verdict_q.push_back(v);
  endfunction

  // results arrive as one-cycle strobes and cannot be held off
  always @(posedge clk) begin : check_results
    verdict_t v;
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        $error("result with no item outstanding: replayed %0d highest_seq %0h",
               replayed, highest_seq);
        err_cnt++;
      end else begin
        v = verdict_q.pop_front();
        if (replayed !== v.replayed) begin
          $error("replayed: expected %0d, got %0d", v.replayed, replayed);
          err_cnt++;
        end
        if (highest_seq !== v.highest) begin
          $error("highest_seq: expected %0h, got %0h", v.highest, highest_seq);
          err_cnt++;
        end
      end
    end
  end

  // called at a falling edge; start stays high unless the sender decides to idle
  task automatic send_item(input logic act, input logic [SEQ_W-1:0] s);
    int gap;
    action = act;
    seq    = s;
    start  = 1'b1;
    // busy read here is the value before the edge, i.e. what the block saw
    do @(posedge clk); while (busy);
    admit_packet(act, s);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      // gap lengths span more than one busy period so pauses land on every phase
      gap   = $urandom_range(1, MAX_GAP);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // hold the sender off until every queued verdict has come back
  task automatic drain_results();
    start = 1'b0;
    while (verdict_q.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  // after reset the ring is empty and the top is zero, so the age test cannot fire
  task automatic test_empty_window();
    send_item(1'b0, '1);
    send_item(1'b0, '0);
    send_item(1'b1, '0);
    send_item(1'b1, '0);   // now in the ring
    send_item(1'b0, '0);
  endtask

  // boundaries of the age test and exact repeats
  task automatic test_window_edges();
    send_item(1'b1, 64'd5);
    send_item(1'b1, 64'd3);                  // below the top but inside the window
    send_item(1'b1, 64'd3);
    send_item(1'b1, 64'd100);
    send_item(1'b0, 64'd100 - WIN);          // exactly WIN below: too old
    send_item(1'b0, 64'd100 - WIN + 1);      // just inside
    send_item(1'b1, 64'd100);                // equal to top, still in ring
    send_item(1'b0, 64'd101);
  endtask

  // top at the largest sequence, then far-below and near-top probes
  task automatic test_extremes();
    send_item(1'b1, '1);
    send_item(1'b0, '0);
    send_item(1'b1, '1);
    send_item(1'b0, {SEQ_W{1'b1}} - WIN);
    send_item(1'b1, {SEQ_W{1'b1}} - WIN + 1);
    send_item(1'b1, 64'h8000_0000_0000_0000);
  endtask

  // mostly sequences near the current top so the window and ring stay busy,
  // with some fully random noise mixed in
  task automatic test_random_traffic(input int n_items);
    logic             act;
    logic [SEQ_W-1:0] s;
    logic [SEQ_W-1:0] rnd;
    for (int k = 0; k < n_items; k++) begin
      rnd = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 10) begin
        act = 1'($urandom_range(0, 1));
        s   = rnd;
      end else begin
        act = ($urandom_range(0, 99) < 70);
        case ($urandom_range(0, 5))
          0: s = win_top + $urandom_range(1, 8);
          1: s = win_top - $urandom_range(0, WIN + 8);
          2: s = (recent_q.size() != 0) ?
                 recent_q[$urandom_range(0, recent_q.size() - 1)] : win_top;
          3: s = win_top - WIN + $urandom_range(0, 1);   // right at the window edge
          4: s = win_top;
          default: s = win_top + (rnd >> $urandom_range(8, 63));
        endcase
      end
      send_item(act, s);
      // occasional full drain, so new items also meet a completely idle block
      if ($urandom_range(0, 99) < 3)
        drain_results();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    idle_pct = 28;
    test_empty_window();
    test_window_edges();
    test_extremes();
    drain_results();
    test_random_traffic(180);
    drain_results();

    idle_pct = 81;
    test_random_traffic(180);
    drain_results();

    // back-to-back items, no sender gaps at all
    idle_pct = 0;
    test_random_traffic(190);

    start = 1'b0;
    while (verdict_q.size() != 0)
      @(posedge clk);
    // let any stray strobe show up before the verdict
    repeat (WIN + 4) @(posedge clk);
    if (err_cnt == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/srf_pkg.sv
rtl/core/srf_cell.sv
rtl/core/sequence_replay_filter_unit.sv
rtl/core/srf_checker.sv
verif/tb_top.sv
